>>> hw/rtl/epcr_pkg.sv
`default_nettype none
package epcr_pkg;

	localparam int unsigned SineSize = 256;
	localparam int unsigned MaxChunkFrames = 4096;
	localparam logic [16:0] Q16One = 17'd65536;

	// Front-to-back queue entry: one classified request.
	typedef struct packed {
		logic signed [15:0] old_s;
		logic signed [15:0] new_s;
		logic               active;
		logic               chunk_end;
		logic [16:0]        start_g;
		logic [16:0]        end_g;
		logic [11:0]        frame;
		logic [11:0]        span;
		logic               ramp;
	} epcr_req_t;

	// Quarter sine table for indexes 0 to SineSize-1; the top entry is kept apart.
	typedef logic [SineSize-1:0][16:0] sine_rom_t;

	// Quarter sine in Q16, polynomial evaluated in Q30 with truncation toward zero.
	function automatic logic [16:0] quarter_sine(input int unsigned i);
		longint t, t2, acc, r;
		begin
			t = (longint'(i) * 64'sd1073741824) / SineSize;
			t2 = (t * t) / 64'sd1073741824;
			acc = 172272;
			acc = -5026995 + (acc * t2) / 64'sd1073741824;
			acc = 85569306 + (acc * t2) / 64'sd1073741824;
			acc = -693598668 + (acc * t2) / 64'sd1073741824;
			acc = 1686629713 + (acc * t2) / 64'sd1073741824;
			r = (acc * t) / 64'sd1073741824;
			if (r < 0) r = 0;
			r = (r + 8192) / 16384;
			if (r > 65536) r = 65536;
			return r[16:0];
		end
	endfunction

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t rom;
		begin
			for (int unsigned k = 0; k < SineSize; k++) rom[k] = quarter_sine(k);
			return rom;
		end
	endfunction

	localparam sine_rom_t SineRom = build_sine_rom();
	localparam logic [16:0] SineTop = quarter_sine(SineSize);

endpackage
`default_nettype wire

>>> hw/rtl/epcr_if.sv
`default_nettype none
interface epcr_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] old_sample;
	logic signed [15:0] new_sample;
	logic [16:0]        fade_ratio;
	logic [12:0]        chunk_frames;
	logic               fade_active;
	modport source (output valid, old_sample, new_sample, fade_ratio, chunk_frames,
		fade_active, input ready);
	modport sink (input valid, old_sample, new_sample, fade_ratio, chunk_frames,
		fade_active, output ready);
endinterface

interface epcr_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] mixed_sample;
	logic               chunk_end;
	modport source (output valid, mixed_sample, chunk_end, input ready);
	modport sink (input valid, mixed_sample, chunk_end, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/epcr_front.sv
`default_nettype none
// Tracks frame and channel position and latches chunk gains.
module epcr_front #(
	parameter int unsigned MAX_CHANNELS = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [3:0]          chans_cfg,
	epcr_in_if.sink                  in_ch,
	output epcr_pkg::epcr_req_t      req,
	output logic                     req_valid,
	input  wire logic                req_ready
);
	localparam int unsigned FrW = $clog2(epcr_pkg::MaxChunkFrames);
	localparam int unsigned ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	logic [FrW-1:0] frame_q;
	logic [ChW-1:0] chan_q;
	logic [16:0]    prev_q, start_q, end_q;
	logic           prev_valid_q;

	logic [4:0]     chans;
	logic [16:0]    frames;
	logic [16:0]    s_g, e_g, drop, st_n, en_n;
	logic           first, last_ch, last_fr, fire;

	always_comb begin
		chans = {1'b0, chans_cfg};
		if (chans == 5'd0) chans = 5'd1;
		if (chans > 5'(MAX_CHANNELS)) chans = 5'(MAX_CHANNELS);
		frames = {4'd0, in_ch.chunk_frames};
		if (frames == 17'd0) frames = 17'd1;
		if (frames > 17'(epcr_pkg::MaxChunkFrames)) frames = 17'(epcr_pkg::MaxChunkFrames);
		first = (frame_q == '0) && (chan_q == '0);
		s_g = (in_ch.fade_ratio > epcr_pkg::Q16One) ? epcr_pkg::Q16One : in_ch.fade_ratio;
		drop = prev_q - s_g;
		e_g = s_g;
		if (prev_valid_q && prev_q > s_g) e_g = (s_g > drop) ? s_g - drop : 17'd0;
		st_n = start_q;
		en_n = end_q;
		if (in_ch.fade_active && first) begin
			st_n = s_g;
			en_n = e_g;
		end
		last_ch = (5'(chan_q) + 5'd1) >= chans;
		last_fr = (17'(frame_q) + 17'd1) >= frames;
	end

	assign req_valid = in_ch.valid;
	assign in_ch.ready = req_ready;
	assign fire = in_ch.valid && req_ready;

	always_comb begin
		req.old_s = in_ch.old_sample;
		req.new_s = in_ch.new_sample;
		req.active = in_ch.fade_active;
		req.chunk_end = last_ch && last_fr;
		req.start_g = st_n;
		req.end_g = en_n;
		req.span = 12'(frames - 17'd1);
		req.frame = (17'(frame_q) < frames - 17'd1) ? 12'(frame_q) : 12'(frames - 17'd1);
		req.ramp = (frames > 17'd1) && (en_n < st_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			chan_q <= '0;
			prev_q <= '0;
			prev_valid_q <= 1'b0;
			start_q <= '0;
			end_q <= '0;
		end else if (fire) begin
			if (!in_ch.fade_active) begin
				prev_valid_q <= 1'b0;
			end else if (first) begin
				prev_q <= s_g;
				prev_valid_q <= 1'b1;
			end
			start_q <= st_n;
			end_q <= en_n;
			if (last_ch) begin
				chan_q <= '0;
				frame_q <= last_fr ? '0 : frame_q + 1'b1;
			end else begin
				chan_q <= chan_q + 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/epcr_fifo.sv
`default_nettype none
// Two-entry queue between the front and the back.
module epcr_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  epcr_pkg::epcr_req_t      wr_data,
	input  wire logic                wr_valid,
	output logic                     wr_ready,
	output epcr_pkg::epcr_req_t      rd_data,
	output logic                     rd_valid,
	input  wire logic                rd_ready
);
	epcr_pkg::epcr_req_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end
endmodule
`default_nettype wire

>>> hw/rtl/epcr_back.sv
`default_nettype none
// Ramp divide, sine lookup and mix; one request at a time.
module epcr_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  epcr_pkg::epcr_req_t      req,
	input  wire logic                req_valid,
	output logic                     req_ready,
	epcr_out_if.source               out_ch
);
	typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_IDX, ST_MUL, ST_SUM, ST_OUT} st_t;
	st_t state_q, state_d;

	epcr_pkg::epcr_req_t r_q;
	logic [28:0] num_q;
	logic [16:0] quo_q;
	logic [11:0] rem_q;
	logic [4:0]  bit_q;
	logic [16:0] gn_q, go_q;
	logic signed [33:0] pn_q, po_q;
	logic signed [15:0] res_q;
	logic        cend_q;

	logic [12:0] trial;
	logic [16:0] gain, angle;
	logic [25:0] idxw;
	logic [8:0]  idx;
	logic signed [34:0] sum;
	logic signed [18:0] qv;

	always_comb begin
		trial = {rem_q, num_q[28]};
		gain = r_q.start_g;
		if (r_q.ramp) gain = r_q.start_g - quo_q;
		angle = epcr_pkg::Q16One - gain;
		idxw = ({9'd0, angle} << 8) + 26'd32768;
		idx = (idxw[25:16] > 10'd256) ? 9'd256 : idxw[24:16];
		sum = 35'(pn_q) + 35'(po_q) + 35'sd32768;
		qv = sum[34:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) state_d = ST_DIV;
			end
			ST_DIV: if (!r_q.ramp || !r_q.active || bit_q == 5'd28) state_d = ST_IDX;
			ST_IDX: state_d = ST_MUL;
			ST_MUL: state_d = ST_SUM;
			ST_SUM: state_d = ST_OUT;
			ST_OUT: if (out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				r_q <= req;
				// numerator = diff*frame + span/2, divided one bit a cycle
				num_q <= 29'(req.start_g - req.end_g) * 29'(req.frame) + 29'(req.span >> 1);
				rem_q <= '0;
				quo_q <= '0;
				bit_q <= '0;
			end
			ST_DIV: begin
				bit_q <= bit_q + 5'd1;
				num_q <= num_q << 1;
				if (trial >= {1'b0, r_q.span}) begin
					rem_q <= 12'(trial - {1'b0, r_q.span});
					quo_q <= {quo_q[15:0], 1'b1};
				end else begin
					rem_q <= trial[11:0];
					quo_q <= {quo_q[15:0], 1'b0};
				end
			end
			ST_IDX: begin
				gn_q <= (idx == 9'd256) ? epcr_pkg::SineTop : epcr_pkg::SineRom[idx[7:0]];
				go_q <= (idx == 9'd0) ? epcr_pkg::SineTop
					: epcr_pkg::SineRom[8'(9'd256 - idx)];
			end
			ST_MUL: begin
				pn_q <= 34'(r_q.new_s) * 34'($signed({1'b0, gn_q}));
				po_q <= 34'(r_q.old_s) * 34'($signed({1'b0, go_q}));
			end
			ST_SUM: begin
				cend_q <= r_q.chunk_end;
				if (!r_q.active) res_q <= r_q.old_s;
				else if (qv > 19'sd32767) res_q <= 16'sh7fff;
				else if (qv < -19'sd32768) res_q <= -16'sh8000;
				else res_q <= qv[15:0];
			end
			default: ;
		endcase
	end

	assign out_ch.valid = state_q == ST_OUT;
	assign out_ch.mixed_sample = res_q;
	assign out_ch.chunk_end = cend_q;
endmodule
`default_nettype wire

>>> hw/rtl/equal_power_crossfade_ramp_top.sv
// Path: an accepted request passes the queue, then the back-end states ST_DIV, ST_IDX,
// ST_MUL, ST_SUM and ST_OUT; a faded sample with a falling ramp stays in ST_DIV for the
// bit-serial divide. The single shared back-end datapath takes one sample at a time;
// the front queue holds two requests so input keeps flowing while a result waits.
// Reset: arst_n clears position, gains and queue; channel_count returns to 2.
`default_nettype none
module equal_power_crossfade_ramp_top #(
	parameter int unsigned MAX_CHANNELS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [3:0] cfg_wdata,
	epcr_in_if.sink         in_ch,
	epcr_out_if.source      out_ch
);
	logic [3:0] chans_q;
	epcr_pkg::epcr_req_t f_req, b_req;
	logic f_valid, f_ready, b_valid, b_ready;

	// The user must write the channel count register only while the block is idle; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) chans_q <= 4'd2;
		else if (cfg_we) chans_q <= cfg_wdata;
	end

	// The front classifies each request and latches chunk gains.
	epcr_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
		.clk, .arst_n, .chans_cfg(chans_q), .in_ch,
		.req(f_req), .req_valid(f_valid), .req_ready(f_ready));

	// The queue lets the front keep taking requests while the back works.
	epcr_fifo u_fifo (
		.clk, .arst_n, .wr_data(f_req), .wr_valid(f_valid), .wr_ready(f_ready),
		.rd_data(b_req), .rd_valid(b_valid), .rd_ready(b_ready));

	// The back computes the ramp gain, looks up sine and cosine and mixes.
	epcr_back u_back (
		.clk, .arst_n, .req(b_req), .req_valid(b_valid), .req_ready(b_ready), .out_ch);
endmodule
`default_nettype wire

>>> test/equal_power_crossfade_ramp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module equal_power_crossfade_ramp_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [3:0] cfg_wdata,
	epcr_in_if.sink         in_mon,
	epcr_out_if.sink        out_mon,
	output int              fail_count,
	output int              pending,
	output int              result_count,
	output int              chunk_end_count
);

	typedef struct packed {
		logic signed [15:0] mixed;
		logic               last;
	} mix_result_t;

	mix_result_t expected_mix_q[$];
	logic [3:0]  chan_count;
	logic [16:0] prev_gain, start_g, end_g;
	logic        prev_valid;
	int unsigned frame_pos, chan_pos;

	// Quarter sine in Q16, truncating Q30 polynomial.
	function automatic longint unsigned sine_q16(input longint unsigned i);
		longint t, t2, acc, r;
		begin
			if (i > 256) i = 256;
			t = (longint'(i) * 64'sd1073741824) / 256;
			t2 = (t * t) / 64'sd1073741824;
			acc = 172272;
			acc = -5026995 + (acc * t2) / 64'sd1073741824;
			acc = 85569306 + (acc * t2) / 64'sd1073741824;
			acc = -693598668 + (acc * t2) / 64'sd1073741824;
			acc = 1686629713 + (acc * t2) / 64'sd1073741824;
			r = (acc * t) / 64'sd1073741824;
			if (r < 0) r = 0;
			r = (r + 8192) / 16384;
			if (r > 65536) r = 65536;
			return r;
		end
	endfunction

	task automatic predict_mix(input logic signed [15:0] old_s, input logic signed [15:0] new_s,
			input logic [16:0] ratio, input logic [12:0] frames_in, input logic active);
		longint unsigned chans, frames, gain, angle, idx, gn, go, span, f, d, s, e, drop;
		longint sum, q;
		mix_result_t r;
		logic last_ch, last_fr;
		begin
			chans = chan_count;
			if (chans < 1) chans = 1;
			if (chans > 8) chans = 8;
			frames = frames_in;
			if (frames < 1) frames = 1;
			if (frames > 4096) frames = 4096;
			if (!active) begin
				prev_valid = 1'b0;
				r.mixed = old_s;
			end else begin
				if (frame_pos == 0 && chan_pos == 0) begin
					s = (ratio > 65536) ? 65536 : ratio;
					e = s;
					if (prev_valid && prev_gain > s) begin
						drop = prev_gain - s;
						e = (s > drop) ? s - drop : 0;
					end
					start_g = s;
					end_g = e;
					prev_gain = s;
					prev_valid = 1'b1;
				end
				gain = start_g;
				if (frames > 1 && end_g < start_g) begin
					span = frames - 1;
					f = (frame_pos < span) ? frame_pos : span;
					d = ((start_g - end_g) * f + span / 2) / span;
					gain = start_g - d;
				end
				if (gain > 65536) gain = 65536;
				angle = 65536 - gain;
				idx = (angle * 256 + 32768) >> 16;
				if (idx > 256) idx = 256;
				gn = sine_q16(idx);
				go = sine_q16(256 - idx);
				sum = longint'(new_s) * longint'(gn) + longint'(old_s) * longint'(go);
				q = (sum + 32768) >>> 16;
				if (q > 32767) q = 32767;
				if (q < -32768) q = -32768;
				r.mixed = q[15:0];
			end
			last_ch = (chan_pos + 1 >= chans);
			last_fr = (frame_pos + 1 >= frames);
			r.last = last_ch && last_fr;
			if (last_ch) begin
				chan_pos = 0;
				frame_pos = last_fr ? 0 : frame_pos + 1;
			end else begin
				chan_pos++;
			end
			expected_mix_q.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mix_result_t exp_r;
		if (!arst_n) begin
			chan_count = 4'd2;
			prev_gain = '0;
			prev_valid = 1'b0;
			start_g = '0;
			end_g = '0;
			frame_pos = 0;
			chan_pos = 0;
			expected_mix_q.delete();
			fail_count = 0;
			result_count = 0;
			chunk_end_count = 0;
		end else begin
			if (cfg_we) chan_count = cfg_wdata;
			if (out_mon.valid && out_mon.ready) begin
				result_count++;
				if (out_mon.chunk_end) chunk_end_count++;
				if (expected_mix_q.size() == 0) begin
					fail_count++;
					$display("%0t: unexpected result mixed=%0d end=%0b", $time,
						out_mon.mixed_sample, out_mon.chunk_end);
				end else begin
					exp_r = expected_mix_q.pop_front();
					if (exp_r.mixed !== out_mon.mixed_sample) begin
						fail_count++;
						$display("%0t: mixed_sample expected %0d actual %0d", $time,
							exp_r.mixed, out_mon.mixed_sample);
					end
					if (exp_r.last !== out_mon.chunk_end) begin
						fail_count++;
						$display("%0t: chunk_end expected %0b actual %0b", $time,
							exp_r.last, out_mon.chunk_end);
					end
				end
			end
			if (in_mon.valid && in_mon.ready)
				predict_mix(in_mon.old_sample, in_mon.new_sample, in_mon.fade_ratio,
					in_mon.chunk_frames, in_mon.fade_active);
		end
		pending = expected_mix_q.size();
	end

endmodule
`default_nettype wire

>>> test/equal_power_crossfade_ramp_top_test.sv
`timescale 1ns / 1ps
`default_nettype none
module equal_power_crossfade_ramp_top_test;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [3:0] cfg_wdata = '0;
	int         fail_count, pending, result_count, chunk_end_count;
	int         hold_off_cycles = 0;
	bit         stall_mode = 1'b0;
	int         request_count = 0;

	epcr_in_if  in_ch ();
	epcr_out_if out_ch ();

	equal_power_crossfade_ramp_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch.sink),
		.out_ch    (out_ch.source)
	);

	equal_power_crossfade_ramp_checker checker_inst (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_mon          (in_ch.sink),
		.out_mon         (out_ch.sink),
		.fail_count      (fail_count),
		.pending         (pending),
		.result_count    (result_count),
		.chunk_end_count (chunk_end_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.old_sample = '0;
		in_ch.new_sample = '0;
		in_ch.fade_ratio = '0;
		in_ch.chunk_frames = '0;
		in_ch.fade_active = 1'b0;
		out_ch.ready = 1'b0;
	end

	// The receiver runs its own stall pattern. A long hold-off request from the
	// stimulus process freezes ready low for a counted number of cycles, so the
	// front queue fills and the block must push back on its input.
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			out_ch.ready <= 1'b0;
		end else if (stall_mode) begin
			out_ch.ready <= ($urandom_range(0, 3) != 0);
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
	end

	// Offers one request and holds it until the block takes it. Valid stays high
	// across back-to-back requests inside a burst, so it is never lowered and raised
	// in the same step.
	task automatic send_request(input logic signed [15:0] old_s, input logic signed [15:0] new_s,
			input logic [16:0] ratio, input logic [12:0] frames, input logic active);
		begin
			in_ch.valid <= 1'b1;
			in_ch.old_sample <= old_s;
			in_ch.new_sample <= new_s;
			in_ch.fade_ratio <= ratio;
			in_ch.chunk_frames <= frames;
			in_ch.fade_active <= active;
			@(posedge clk);
			while (!in_ch.ready) @(posedge clk);
			request_count++;
		end
	endtask

	task automatic pause_sender(input int cycles);
		begin
			in_ch.valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Lets every outstanding result drain, then gives the ramp divide time to
	// finish before the channel count is touched.
	task automatic drain_and_write(input logic [3:0] count);
		begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
			while (pending != 0) @(posedge clk);
			repeat (40) @(posedge clk);
			cfg_we <= 1'b1;
			cfg_wdata <= count;
			@(posedge clk);
			cfg_we <= 1'b0;
		end
	endtask

	// Sends a run of well-formed chunks: a fixed frame count, a ratio that falls
	// from chunk to chunk so the ramp engages, and random samples. A few requests
	// clear the fade flag or carry an odd ratio or frame count as noise.
	task automatic send_chunks(input int chunks, input int chans);
		int   frames, ratio, step, burst;
		logic active;
		logic [12:0] frames_field;
		logic [16:0] ratio_field;
		begin
			burst = $urandom_range(1, 12);
			ratio = $urandom_range(0, 65536);
			step = $urandom_range(0, 20000);
			for (int c = 0; c < chunks; c++) begin
				frames = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40)
					: $urandom_range(1, 6);
				for (int k = 0; k < frames * chans; k++) begin
					active = ($urandom_range(0, 15) != 0);
					frames_field = 13'(frames);
					ratio_field = 17'(ratio);
					if ($urandom_range(0, 30) == 0) frames_field = 13'($urandom);
					if ($urandom_range(0, 30) == 0) ratio_field = 17'($urandom);
					send_request(16'($urandom), 16'($urandom), ratio_field, frames_field,
						active);
					if (--burst == 0) begin
						pause_sender($urandom_range(1, 8));
						burst = $urandom_range(1, 12);
					end
				end
				ratio = (ratio > step) ? ratio - step : $urandom_range(0, 65536);
				// Long chunks are rare and costly; keep the random part near its size.
				if (request_count > 760) break;
			end
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset channel count of two, then at one: sample extremes
		// at full and zero ratio, an oversized ratio, zero and oversized frame counts, a
		// falling ramp that clamps at zero, and a fade switched off then on mid-chunk.
		send_request(16'sh7fff, 16'sh7fff, 17'd65536, 13'd1, 1'b1);
		send_request(-16'sh8000, -16'sh8000, 17'd65536, 13'd1, 1'b1);
		send_request(16'sh7fff, -16'sh8000, 17'd0, 13'd1, 1'b1);
		send_request(-16'sh8000, 16'sh7fff, 17'd0, 13'd1, 1'b1);
		send_request(16'sh1234, 16'sh4321, 17'h1ffff, 13'd0, 1'b1);
		send_request(16'sh0fff, 16'sh7000, 17'd40000, 13'd0, 1'b1);
		send_request(16'sh7fff, 16'sh7fff, 17'd60000, 13'h1fff, 1'b1);
		send_request(16'sh5555, -16'sh5556, 17'd60000, 13'h1fff, 1'b1);
		drain_and_write(4'd1);
		send_request(16'sh0100, 16'sh0200, 17'd65536, 13'd3, 1'b1);
		send_request(16'sh0100, 16'sh0200, 17'd65536, 13'd3, 1'b1);
		send_request(16'sh0100, 16'sh0200, 17'd65536, 13'd3, 1'b1);
		for (int k = 0; k < 4; k++)
			send_request(-16'sh7000, 16'sh7000, 17'd20000, 13'd4, 1'b1);
		send_request(16'sh2222, 16'sh3333, 17'd10000, 13'd3, 1'b0);
		send_request(16'sh2222, 16'sh3333, 17'd10000, 13'd3, 1'b1);
		send_request(16'sh2222, 16'sh3333, 17'd10000, 13'd3, 1'b1);
		send_request(16'sh1111, 16'sh1111, 17'd5000, 13'd2, 1'b0);
		send_request(16'sh1111, 16'sh1111, 17'd5000, 13'd2, 1'b0);

		// Channel counts of zero and above eight are both clamped by the block.
		drain_and_write(4'd0);
		send_chunks(3, 1);
		drain_and_write(4'd15);
		send_chunks(2, 8);

		// Random part, with the channel count changed between phases.
		drain_and_write(4'd8);
		send_chunks(6, 8);
		// The receiver holds off while the sender keeps offering requests.
		hold_off_cycles = 300;
		send_chunks(8, 8);
		// The sender waits until every expected result has come back.
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		send_chunks(6, 8);
		drain_and_write(4'd3);
		send_chunks(30, 3);
		drain_and_write(4'd2);
		send_chunks(40, 2);
		drain_and_write(4'd1);
		while (request_count < 700) send_chunks(10, 1);

		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d requests over channel counts 0 to 15; checked %0d results,",
			request_count, result_count);
		$display("%0d of them marking a chunk end.", chunk_end_count);
		if (fail_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// A watchdog ends a run that has not finished in time and reports mismatches.
	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
hw/rtl/epcr_pkg.sv
hw/rtl/epcr_if.sv
hw/rtl/epcr_front.sv
hw/rtl/epcr_fifo.sv
hw/rtl/epcr_back.sv
hw/rtl/equal_power_crossfade_ramp_top.sv
test/equal_power_crossfade_ramp_checker.sv
test/equal_power_crossfade_ramp_top_test.sv
